>>> src/bqe_pkg.sv
// bqe_pkg: shared types, constants, coefficient rom and sequencer microcode
// for the biquad cascade equalizer. No dependencies.
package bqe_pkg;

  localparam int STAGES_DEF         = 4;
  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 30;

  localparam int VAL_W    = 24;  // section values, signed q1.23
  localparam int ACC_W    = 48;
  localparam int ACC_FRAC = 39;
  localparam int Y_SHIFT  = ACC_FRAC - (VAL_W - 1);
  localparam int UC_DEPTH = 9;
  localparam int PC_W     = $clog2(UC_DEPTH);

  // multiplier operand select
  localparam logic MUL_V  = 1'b0;
  localparam logic MUL_RD = 1'b1;

  // delay line write source
  localparam logic [1:0] WR_V  = 2'd0;
  localparam logic [1:0] WR_RD = 2'd1;
  localparam logic [1:0] WR_Y  = 2'd2;

  // sequencer jump kinds
  localparam logic [1:0] JMP_NEXT  = 2'd0;
  localparam logic [1:0] JMP_STAGE = 2'd1;
  localparam logic [1:0] JMP_DONE  = 2'd2;

  localparam logic [PC_W-1:0] PC_FIRST = PC_W'(0);
  localparam logic [PC_W-1:0] PC_DONE  = PC_W'(UC_DEPTH - 1);

  typedef struct packed {
    logic       coef_ld;
    logic [2:0] coef_j;
    logic       rd_en;
    logic [1:0] rd_off;
    logic       mul_en;
    logic       mul_src;
    logic       acc_clr;
    logic       acc_add;
    logic       wr_en;
    logic [1:0] wr_off;
    logic [1:0] wr_src;
    logic       v_ld_y;
    logic [1:0] jump;
  } ctrl_word_t;

  // per section: x1,x2,y1,y2 live at offsets 0..3 of the section's slot
  localparam ctrl_word_t UCODE [UC_DEPTH] = '{
    '{coef_ld: 1'b1, coef_j: 3'd0, default: '0},
    '{coef_ld: 1'b1, coef_j: 3'd1, rd_en: 1'b1, rd_off: 2'd0,
      mul_en: 1'b1, mul_src: MUL_V, acc_clr: 1'b1, default: '0},
    '{coef_ld: 1'b1, coef_j: 3'd2, rd_en: 1'b1, rd_off: 2'd1,
      mul_en: 1'b1, mul_src: MUL_RD, acc_add: 1'b1,
      wr_en: 1'b1, wr_off: 2'd1, wr_src: WR_RD, default: '0},
    '{coef_ld: 1'b1, coef_j: 3'd3, rd_en: 1'b1, rd_off: 2'd2,
      mul_en: 1'b1, mul_src: MUL_RD, acc_add: 1'b1,
      wr_en: 1'b1, wr_off: 2'd0, wr_src: WR_V, default: '0},
    '{coef_ld: 1'b1, coef_j: 3'd4, rd_en: 1'b1, rd_off: 2'd3,
      mul_en: 1'b1, mul_src: MUL_RD, acc_add: 1'b1,
      wr_en: 1'b1, wr_off: 2'd3, wr_src: WR_RD, default: '0},
    '{mul_en: 1'b1, mul_src: MUL_RD, acc_add: 1'b1, default: '0},
    '{acc_add: 1'b1, default: '0},
    '{wr_en: 1'b1, wr_off: 2'd2, wr_src: WR_Y, v_ld_y: 1'b1,
      jump: JMP_STAGE, default: '0},
    '{jump: JMP_DONE, default: '0}
  };

  localparam logic signed [31:0] Q30_MTWO = 32'sh8000_0000;

  // rows: band k uses rows 3k (9 dB), 3k+1 (6 dB), 3k+2 (3 dB); b0 b1 b2 a1 a2
  localparam logic signed [31:0] EQ_ROM [12][5] = '{
    '{32'sd1078616271, Q30_MTWO, 32'sd1069357887, 32'sd2121224536, -32'sd1047967224},
    '{32'sd1082005119, Q30_MTWO, 32'sd1065969038, 32'sd2115481079, -32'sd1042222454},
    '{32'sd1097085001, Q30_MTWO, 32'sd1050889157, 32'sd2080058836, -32'sd1006792121},
    '{32'sd1090632098, Q30_MTWO, 32'sd1062312166, 32'sd2065463650, -32'sd996973882},
    '{32'sd1100998052, Q30_MTWO, 32'sd1051946213, 32'sd2048895574, -32'sd980363678},
    '{32'sd1147125026, Q30_MTWO, 32'sd1005819239, 32'sd1950491685, -32'sd881709567},
    '{32'sd1142215952, Q30_MTWO, 32'sd1055260289, 32'sd1888061613, -32'sd858273136},
    '{32'sd1174044359, Q30_MTWO, 32'sd1023431881, 32'sd1846160462, -32'sd815396542},
    '{32'sd1315676113, Q30_MTWO, 32'sd881800127, 32'sd1620035741, -32'sd584007725},
    '{32'sd1412476299, Q30_MTWO, 32'sd1138121459, 32'sd1387459473, -32'sd574164098},
    '{32'sd1512898484, Q30_MTWO, 32'sd1037699273, 32'sd1318097272, -32'sd491781596},
    '{32'sd1959762504, Q30_MTWO, 32'sd590835254, 32'sd1002794294, -32'sd117291635}
  };

endpackage

>>> src/bqe_datapath.sv
// bqe_datapath: delay line memory, coefficient select, shared mac and
// section output saturation, driven by one control word per cycle.
// Depends on bqe_pkg.
module bqe_datapath #(
  parameter int STAGES         = bqe_pkg::STAGES_DEF,
  parameter int COEF_FRAC_BITS = bqe_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  bqe_pkg::ctrl_word_t                     ctrl,
  input  logic [$clog2(STAGES > 1 ? STAGES : 2)-1:0] stage,
  input  logic [7:0]                              band_levels,
  input  logic                                    ld_in,
  input  logic signed [bqe_pkg::VAL_W-1:0]        in_val,
  input  logic                                    clr,
  output logic signed [bqe_pkg::VAL_W-1:0]        v_out
);
  import bqe_pkg::*;

  localparam int NE      = 4 * STAGES;
  localparam int AW      = $clog2(NE);
  localparam int CW      = COEF_FRAC_BITS + 2;
  localparam int CSH     = 30 - COEF_FRAC_BITS;
  localparam int RND_ADD = (CSH > 0) ? (1 << (CSH - 1)) : 0;
  localparam int PW      = CW + VAL_W;
  localparam int SHR     = (COEF_FRAC_BITS >= 16) ? COEF_FRAC_BITS - 16 : 0;
  localparam int SHL     = (COEF_FRAC_BITS < 16) ? 16 - COEF_FRAC_BITS : 0;

  logic signed [VAL_W-1:0] delay_mem [NE];
  logic [NE-1:0]           valid_r;
  logic signed [VAL_W-1:0] rd_r;
  logic signed [CW-1:0]    coef_r, coef_nxt;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [VAL_W-1:0] v_r;

  logic [AW-1:0]           rd_addr, wr_addr;
  logic [1:0]              lvl;
  logic [3:0]              row;
  logic signed [31:0]      rom_val;
  logic signed [32:0]      rnd;
  logic signed [VAL_W-1:0] opnd, y_val, wr_data;
  logic signed [63:0]      p_ext;
  logic signed [ACC_W-1:0] scaled, y_t, y_q;

  assign rd_addr = AW'({stage, ctrl.rd_off});
  assign wr_addr = AW'({stage, ctrl.wr_off});

  // bands beyond the fourth are always bypass
  always_comb begin
    if (32'(stage) < 4) begin
      lvl = 2'(band_levels >> {stage, 1'b0});
    end else begin
      lvl = 2'd0;
    end
    row     = 4'({stage, 1'b0}) + 4'(stage) + 4'(2'd3 - lvl);
    rom_val = EQ_ROM[row][ctrl.coef_j];
    rnd     = 33'(rom_val) + 33'(RND_ADD);
    if (lvl == 2'd0) begin
      coef_nxt = (ctrl.coef_j == 3'd0) ? CW'(64'sd1 <<< COEF_FRAC_BITS) : '0;
    end else begin
      coef_nxt = CW'(rnd >>> CSH);
    end
  end

  assign opnd   = (ctrl.mul_src == MUL_RD) ? rd_r : v_r;
  assign p_ext  = 64'(prod_r);
  assign scaled = ACC_W'((p_ext >>> SHR) <<< SHL);

  always_comb begin
    if (ctrl.acc_clr) begin
      acc_nxt = '0;
    end else if (ctrl.acc_add) begin
      acc_nxt = acc_r + scaled;
    end else begin
      acc_nxt = acc_r;
    end
  end

  // round half up and saturate to q1.23
  always_comb begin
    y_t = acc_r + ACC_W'(64'sd1 <<< (Y_SHIFT - 1));
    y_q = y_t >>> Y_SHIFT;
    if (y_q > ACC_W'((64'sd1 <<< (VAL_W - 1)) - 1)) begin
      y_val = VAL_W'((64'sd1 <<< (VAL_W - 1)) - 1);
    end else if (y_q < ACC_W'(-(64'sd1 <<< (VAL_W - 1)))) begin
      y_val = VAL_W'(-(64'sd1 <<< (VAL_W - 1)));
    end else begin
      y_val = VAL_W'(y_q);
    end
  end

  always_comb begin
    case (ctrl.wr_src)
      WR_V:    wr_data = v_r;
      WR_RD:   wr_data = rd_r;
      WR_Y:    wr_data = y_val;
      default: wr_data = v_r;
    endcase
  end

  // an entry not written since reset or the last cfg_we write reads as zero
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      delay_mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_r <= valid_r[rd_addr] ? delay_mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= '0;
    end else if (ctrl.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.coef_ld) begin
      coef_r <= coef_nxt;
    end
    if (ctrl.mul_en) begin
      prod_r <= PW'(coef_r * opnd);
    end
    acc_r <= acc_nxt;
    if (ld_in) begin
      v_r <= in_val;
    end else if (ctrl.v_ld_y) begin
      v_r <= y_val;
    end
  end

  assign v_out = v_r;

endmodule

>>> src/biquad_cascade_equalizer.sv
// biquad_cascade_equalizer: top level, microcode sequencer, stream ports,
// level register and output rounding. Depends on bqe_pkg, bqe_datapath.
//
// Usage: samples enter on the in_ stream (in_tdata sample, in_tlast block
// end) and leave on the out_ stream, one result beat per input beat, in
// order, with tlast copied. Each sample runs through STAGES direct-form-I
// biquad sections on one shared multiply-accumulate unit; a nine-word
// microcode program steps through one section and is rerun per section by
// a conditional jump. An input beat is taken when the block is not busy;
// the block stays busy until the last section's result is loaded into the
// output register, so it takes a new sample only after the last one is
// done. The result sits in an output register, so a new input is accepted
// while it waits; if the receiver still holds off when the next result is
// ready, the sequencer waits on its final step. cfg_we writes band_levels
// and clears the delay line at once. Reset (rst_n low, synchronous) clears
// band_levels, the delay line, the busy flag and the output valid flag.
module biquad_cascade_equalizer #(
  parameter int STAGES         = bqe_pkg::STAGES_DEF,
  parameter int SAMPLE_WIDTH   = bqe_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bqe_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,   // sample_in
  input  logic                              in_tlast,   // block_end
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata,  // sample_out
  output logic                              out_tlast,  // block_end_out
  input  logic                              cfg_we,
  input  logic [7:0]                        cfg_wdata   // band_levels
);
  import bqe_pkg::*;

  localparam int TW   = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int STW  = $clog2(STAGES > 1 ? STAGES : 2);
  localparam int SH   = VAL_W - SAMPLE_WIDTH;
  localparam int ORND = (SH > 0) ? (1 << (SH - 1)) : 0;
  localparam int OW   = VAL_W + 1;
  localparam int SMAX = (1 << (SAMPLE_WIDTH - 1)) - 1;

  logic [7:0]              band_levels_r;
  logic                    busy_r;
  logic [PC_W-1:0]         pc_r, pc_nxt;
  logic [STW-1:0]          stage_r, stage_nxt;
  logic                    last_r;
  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                    out_last_r;

  ctrl_word_t              cw;
  logic                    in_acc, done, busy_nxt;
  logic signed [VAL_W-1:0] in_val, dp_v;
  logic signed [OW-1:0]    o_t, o_q;
  logic [SAMPLE_WIDTH-1:0] o_sat;

  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && !busy_r;
  assign cw        = busy_r ? UCODE[pc_r] : '0;
  assign in_val    = VAL_W'($signed(in_tdata[SAMPLE_WIDTH-1:0])) <<< SH;

  // the final step holds until the output register is free
  assign done = busy_r && (cw.jump == JMP_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    pc_nxt    = pc_r;
    stage_nxt = stage_r;
    busy_nxt  = busy_r;
    if (in_acc) begin
      pc_nxt    = PC_FIRST;
      stage_nxt = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      case (cw.jump)
        JMP_NEXT: pc_nxt = pc_r + PC_W'(1);
        JMP_STAGE: begin
          if (32'(stage_r) == STAGES - 1) begin
            pc_nxt = PC_DONE;
          end else begin
            pc_nxt    = PC_FIRST;
            stage_nxt = stage_r + STW'(1);
          end
        end
        JMP_DONE: begin
          if (done) begin
            busy_nxt = 1'b0;
          end
        end
        default: pc_nxt = PC_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      pc_r          <= PC_FIRST;
      stage_r       <= '0;
      band_levels_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      pc_r    <= pc_nxt;
      stage_r <= stage_nxt;
      if (cfg_we) begin
        band_levels_r <= cfg_wdata;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // round half up and saturate the last section's value to a sample
  always_comb begin
    o_t = OW'(dp_v) + OW'(ORND);
    o_q = o_t >>> SH;
    if (o_q > OW'(SMAX)) begin
      o_sat = SAMPLE_WIDTH'(SMAX);
    end else if (o_q < OW'(-SMAX - 1)) begin
      o_sat = SAMPLE_WIDTH'(-SMAX - 1);
    end else begin
      o_sat = SAMPLE_WIDTH'(o_q);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      last_r <= in_tlast;
    end
    if (done) begin
      out_sample_r <= o_sat;
      out_last_r   <= last_r;
    end
  end

  bqe_datapath #(
    .STAGES         (STAGES),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (cw),
    .stage       (stage_r),
    .band_levels (band_levels_r),
    .ld_in       (in_acc),
    .in_val      (in_val),
    .clr         (cfg_we),
    .v_out       (dp_v)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TW'(out_sample_r);
  assign out_tlast  = out_last_r;

endmodule
